// ----- sv/tun_pkg.sv -----
// ----------------------------------------------------------------------------
// tun_pkg
// Shared widths and types for the triangle unit normal block.
// ----------------------------------------------------------------------------
package tun_pkg;

  localparam int VW    = 16;   // vertex coordinate, Q8.8
  localparam int EW    = 17;   // edge component
  localparam int CW    = 35;   // cross product component, signed
  localparam int MW    = 34;   // cross product magnitude
  localparam int SQW   = 68;   // square of one magnitude
  localparam int NSW   = 70;   // sum of three squares
  localparam int LW    = 101;  // compare width for q^2 * |N|^2
  localparam int QB    = 15;   // bits of the unsigned result, 0..16384
  localparam int OW    = 16;   // result component, Q2.14
  localparam int LSH   = 28;   // 2^28 scale of the numerator
  localparam int DEPTH = 4;    // job queue entries
  localparam int PW    = 2;    // queue pointer width

  typedef struct packed {
    logic [NSW-1:0]      sq;
    logic [2:0][LW-1:0]  lim;
    logic [2:0]          neg;
    logic                degen;
  } tun_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tun_qst_t;

  typedef struct packed {
    logic [NSW-1:0]      sq;
    logic [2:0][LW-1:0]  lim;
    logic [2:0][LW-1:0]  p;
    logic [2:0][LW-1:0]  r;
    logic [2:0][QB-1:0]  q;
    logic [2:0]          neg;
    logic                degen;
  } tun_stage_t;

endpackage

// ----- sv/tun_front.sv -----
// ----------------------------------------------------------------------------
// tun_front
// Edge vectors, cross product, squared norm; pushes one job per triangle.
// ----------------------------------------------------------------------------
module tun_front
  import tun_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [143:0]    in_tdata,
  input  tun_qst_t        qst,
  output logic            push,
  output tun_job_t        job
);

  logic                        adv;
  logic                        v1_r, v2_r, v3_r;
  logic signed [2:0][EW-1:0]   e1_r, e2_r;
  logic signed [2:0][CW-1:0]   n_r;
  logic [2:0][SQW-1:0]         sqc_r;
  logic [2:0]                  neg_r;
  logic [2:0]                  nz_r;

  logic signed [2:0][EW-1:0]   e1_nxt, e2_nxt;
  logic signed [2:0][CW-1:0]   n_nxt;
  logic [2:0][MW-1:0]          mag;

  assign push      = v3_r && !qst.full;
  assign adv       = !v3_r || !qst.full;
  assign in_tready = adv;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EW'($signed(in_tdata[(3+i)*VW +: VW])) - EW'($signed(in_tdata[i*VW +: VW]));
      e2_nxt[i] = EW'($signed(in_tdata[(6+i)*VW +: VW])) - EW'($signed(in_tdata[i*VW +: VW]));
    end
    n_nxt[0] = CW'($signed(e1_r[1])) * CW'($signed(e2_r[2]))
             - CW'($signed(e1_r[2])) * CW'($signed(e2_r[1]));
    n_nxt[1] = CW'($signed(e1_r[2])) * CW'($signed(e2_r[0]))
             - CW'($signed(e1_r[0])) * CW'($signed(e2_r[2]));
    n_nxt[2] = CW'($signed(e1_r[0])) * CW'($signed(e2_r[1]))
             - CW'($signed(e1_r[1])) * CW'($signed(e2_r[0]));
    for (int i = 0; i < 3; i++) begin
      mag[i] = n_r[i][CW-1] ? MW'(-n_r[i]) : MW'(n_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r <= e1_nxt;
      e2_r <= e2_nxt;
      n_r  <= n_nxt;
      for (int i = 0; i < 3; i++) begin
        sqc_r[i] <= mag[i] * mag[i];
        neg_r[i] <= n_r[i][CW-1];
        nz_r[i]  <= (n_r[i] != '0);
      end
    end
  end

  always_comb begin
    job.sq = NSW'(sqc_r[0]) + NSW'(sqc_r[1]) + NSW'(sqc_r[2]);
    for (int i = 0; i < 3; i++) begin
      job.lim[i] = LW'(sqc_r[i]) << LSH;
    end
    job.neg   = neg_r;
    job.degen = (nz_r == 3'b000);
  end

endmodule

// ----- sv/tun_fifo.sv -----
// ----------------------------------------------------------------------------
// tun_fifo
// Short job queue between the front and back parts.
// ----------------------------------------------------------------------------
module tun_fifo
  import tun_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tun_job_t  wr_job,
  input  logic      pop,
  output tun_job_t  rd_job,
  output tun_qst_t  qst
);

  tun_job_t          mem [DEPTH];
  logic [PW-1:0]     wp_r, rp_r;
  logic [PW:0]       cnt_r;

  assign qst.full  = (cnt_r == (PW+1)'(DEPTH));
  assign qst.empty = (cnt_r == '0);
  assign rd_job    = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    qst.full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    qst.empty |-> !pop) else $error("queue underflow");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(DEPTH)) else $error("queue count out of range");
`endif

endmodule

// ----- sv/tun_back.sv -----
// ----------------------------------------------------------------------------
// tun_back
// Bit-per-stage search for each normal component; output register.
// ----------------------------------------------------------------------------
module tun_back
  import tun_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  tun_job_t      rd_job,
  input  tun_qst_t      qst,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [47:0]   out_tdata,
  output logic [0:0]    out_tuser
);

  logic                adv;
  logic [QB:0]         vld_r;
  tun_stage_t          st_r   [QB+1];
  tun_stage_t          st_nxt [QB+1];

  assign adv = !vld_r[QB] || out_tready;
  assign pop = adv && !qst.empty;

  always_comb begin
    st_nxt[0].sq    = rd_job.sq;
    st_nxt[0].lim   = rd_job.lim;
    st_nxt[0].neg   = rd_job.neg;
    st_nxt[0].degen = rd_job.degen;
    st_nxt[0].p     = '0;
    st_nxt[0].r     = '0;
    st_nxt[0].q     = '0;
  end

  // stage s tries bit QB-1-s: (q+2^k)^2 sq = q^2 sq + 2^(k+1) q sq + 2^2k sq
  for (genvar s = 0; s < QB; s++) begin : g_stage
    localparam int K = QB - 1 - s;
    logic [LW-1:0] sqx;
    logic [2:0][LW-1:0] cand;
    logic [2:0] take;
    always_comb begin
      sqx = LW'(st_r[s].sq);
      st_nxt[s+1] = st_r[s];
      for (int c = 0; c < 3; c++) begin
        cand[c] = st_r[s].p[c] + (st_r[s].r[c] << (K+1)) + (sqx << (2*K));
        take[c] = (cand[c] <= st_r[s].lim[c]);
        if (take[c]) begin
          st_nxt[s+1].p[c] = cand[c];
          st_nxt[s+1].r[c] = st_r[s].r[c] + (sqx << K);
          st_nxt[s+1].q[c] = st_r[s].q[c] | (QB'(1) << K);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[QB-1:0], pop};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int s = 0; s <= QB; s++) st_r[s] <= st_nxt[s];
    end
  end

  logic [2:0][OW-1:0] nrm;
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (st_r[QB].degen)       nrm[c] = '0;
      else if (st_r[QB].neg[c]) nrm[c] = -{1'b0, st_r[QB].q[c]};
      else                      nrm[c] = {1'b0, st_r[QB].q[c]};
    end
  end

  assign out_tvalid   = vld_r[QB];
  assign out_tdata    = {nrm[2], nrm[1], nrm[0]};
  assign out_tuser[0] = st_r[QB].degen;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0)) else $error("degenerate nonzero");
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !st_r[QB].degen) |->
      (st_r[QB].q[0] <= QB'(16384) && st_r[QB].q[1] <= QB'(16384)
       && st_r[QB].q[2] <= QB'(16384))) else $error("component too large");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> (vld_r == $past(vld_r))) else $error("pipeline moved while stalled");
`endif

endmodule

// ----- sv/triangle_unit_normal.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit face normal of a triangle, Q8.8 vertices in, Q2.14 normal out.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream: one beat per triangle, nine Q8.8 coordinates in in_tdata.
//  - Output stream: one beat per triangle, in order; out_tdata holds the
//    three Q2.14 components (truncated toward zero), out_tuser the
//    degenerate flag (cross product exactly zero, normal forced to zero).
//  - Throughput: one triangle per cycle, sustained while out_tready stays high.
//  - Register path: 3 front stages (edges, cross product, squares), the
//    job queue entry, the queue read register, then 15 search stages,
//    one result bit per stage for all three components; the last stage
//    is the output.
//  - The front stalls only when the 4-entry job queue is full; the back
//    stalls as a whole while out_tvalid is high and out_tready is low.
//  - Reset (synchronous, rst_n low) drops all beats in flight and empties
//    the queue; there is no other state.
// ----------------------------------------------------------------------------
module triangle_unit_normal
  import tun_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // vertex_a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 16 bits each from bit 0
  input  logic [143:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // normal_x [15:0], normal_y [31:16], normal_z [47:32]
  output logic [47:0]   out_tdata,
  // degenerate [0]
  output logic [0:0]    out_tuser
);

  tun_qst_t  qst;
  tun_job_t  wr_job, rd_job;
  logic      push, pop;

  tun_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .qst       (qst),
    .push      (push),
    .job       (wr_job)
  );

  tun_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (wr_job),
    .pop    (pop),
    .rd_job (rd_job),
    .qst    (qst)
  );

  tun_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_job     (rd_job),
    .qst        (qst),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sim/triangle_unit_normal_test.sv -----
// ----------------------------------------------------------------------------
// triangle_unit_normal_test
// Stream test of the triangle unit normal block: random and corner triangles
// go in with random gaps, normals are predicted bit exact and checked in order.
// ----------------------------------------------------------------------------
module triangle_unit_normal_test;
  import tun_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] nz;
    logic signed [15:0] ny;
    logic signed [15:0] nx;
    logic               degen;
  } normal_t;

  localparam int WATCHDOG = 4000;
  localparam int N_RANDOM = 430;
  localparam int HOLD_AT  = 150;
  localparam int HOLD_LEN = 200;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [47:0]  out_tdata;
  logic [0:0]   out_tuser;

  logic [143:0] tri_queue[$];     // triangles waiting to be driven
  normal_t      normal_queue[$];  // normals expected, oldest first
  int           errors = 0;
  int           idle_cycles = 0;
  int           cycle = 0;
  int           hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  triangle_unit_normal uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  // Largest q in 0..16384 with q^2 * |N|^2 <= N_i^2 * 2^28, signed like N_i.
  function automatic logic [15:0] unit_comp(logic signed [35:0] c, logic [69:0] sq);
    logic [35:0]  mag;
    logic [127:0] lim;
    logic [127:0] prod;
    int           lo, hi, mid;
    mag = c < 0 ? -c : c;
    lim = ({92'd0, mag} * {92'd0, mag}) << 28;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      prod = {58'd0, sq} * 128'(mid * mid);
      if (prod <= lim) lo = mid;
      else hi = mid - 1;
    end
    return c < 0 ? 16'(-lo) : 16'(lo);
  endfunction

  function automatic normal_t face_normal(logic [143:0] t);
    logic signed [17:0] v[9];
    logic signed [17:0] e1x, e1y, e1z, e2x, e2y, e2z;
    logic signed [35:0] cx, cy, cz;
    logic [69:0]        sq;
    normal_t            r;
    for (int i = 0; i < 9; i++) v[i] = 18'(signed'(t[i*16 +: 16]));
    e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
    e2x = v[6] - v[0]; e2y = v[7] - v[1]; e2z = v[8] - v[2];
    cx = e1y * e2z - e1z * e2y;
    cy = e1z * e2x - e1x * e2z;
    cz = e1x * e2y - e1y * e2x;
    r = '0;
    if (cx == 0 && cy == 0 && cz == 0) begin
      r.degen = 1'b1;
      return r;
    end
    sq = 70'(cx) * 70'(cx) + 70'(cy) * 70'(cy) + 70'(cz) * 70'(cz);
    r.nx = unit_comp(cx, sq);
    r.ny = unit_comp(cy, sq);
    r.nz = unit_comp(cz, sq);
    return r;
  endfunction

  function automatic logic [143:0] pack_tri(int a[9]);
    logic [143:0] t;
    for (int i = 0; i < 9; i++) t[i*16 +: 16] = 16'(a[i]);
    return t;
  endfunction

  function automatic void add_tri(int a[9]);
    tri_queue = {tri_queue, pack_tri(a)};
  endfunction

  // idle roughly 27 percent of the time, except in a clean stretch mid-run
  function automatic bit take_break();
    if (cycle > 400 && cycle < 520) return 1'b0;
    return $urandom_range(99) < 27;
  endfunction

  // driver: one nonblocking update of valid per edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (tri_queue.size() > 0 && !take_break()) begin
          in_tdata <= tri_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // accepted input beats feed the predictor
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) normal_queue = {normal_queue, face_normal(in_tdata)};
  end

  // receiver: one long hold-off, counted here, fills the block's queue
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      out_tready <= 1'b0;
    end else if (cycle == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= !take_break();
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    normal_t exp_n;
    cycle <= cycle + 1;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (normal_queue.size() == 0) begin
          $error("unexpected output beat");
          errors++;
        end else begin
          exp_n = normal_queue.pop_front();
          if (out_tdata[15:0] !== exp_n.nx) begin
            $error("normal_x exp %0d got %0d", exp_n.nx, $signed(out_tdata[15:0]));
            errors++;
          end
          if (out_tdata[31:16] !== exp_n.ny) begin
            $error("normal_y exp %0d got %0d", exp_n.ny, $signed(out_tdata[31:16]));
            errors++;
          end
          if (out_tdata[47:32] !== exp_n.nz) begin
            $error("normal_z exp %0d got %0d", exp_n.nz, $signed(out_tdata[47:32]));
            errors++;
          end
          if (out_tuser[0] !== exp_n.degen) begin
            $error("degenerate exp %0b got %0b", exp_n.degen, out_tuser[0]);
            errors++;
          end
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_left > 0)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int a[9];
    int r;
    // directed: extremes, degenerate shapes, axis aligned and sign patterns
    a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};                          add_tri(a);
    a = '{0, 0, 0, 256, 0, 0, 0, 256, 0};                      add_tri(a);
    a = '{0, 0, 0, 0, 256, 0, 256, 0, 0};                      add_tri(a);
    a = '{0, 0, 0, 0, 0, 256, 256, 0, 0};                      add_tri(a);
    a = '{0, 0, 0, 0, 256, 0, 0, 0, 256};                      add_tri(a);
    a = '{-32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767, -32768};
    add_tri(a);
    a = '{32767, 32767, 32767, -32768, 32767, 32767, 32767, -32768, 32767};
    add_tri(a);
    a = '{-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767};
    add_tri(a);
    a = '{-32768, 32767, -32768, 32767, -32768, 32767, 32767, 32767, -32768};
    add_tri(a);
    a = '{1, 2, 3, 2, 4, 6, 3, 6, 9};                          add_tri(a);
    a = '{100, 100, 100, 100, 100, 100, 5, 7, 9};              add_tri(a);
    a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};                 add_tri(a);
    a = '{0, 0, 0, 1, 0, 0, 0, 1, 0};                          add_tri(a);
    a = '{0, 0, 0, 1, 1, 0, 0, 1, 1};                          add_tri(a);
    a = '{0, 0, 0, 32767, 0, 0, 0, 1, 0};                      add_tri(a);
    a = '{0, 0, 0, 3, 1, 4, 1, 5, 9};                          add_tri(a);
    a = '{-32768, 0, 0, 32767, 0, 0, 0, 0, -32768};            add_tri(a);
    for (int i = 0; i < N_RANDOM; i++) begin
      r = $urandom_range(9);
      for (int k = 0; k < 9; k++) begin
        if (r < 5) a[k] = $urandom_range(65535);
        else if (r < 8) a[k] = $urandom_range(1023) - 512;
        else a[k] = $urandom_range(1) ? 32767 - $urandom_range(3) : -32768 + $urandom_range(3);
      end
      if (r == 9) begin
        // collinear: c = a + 2 * (b - a) when it fits
        for (int k = 0; k < 3; k++) begin
          a[k] = $urandom_range(2047) - 1024;
          a[k+3] = $urandom_range(2047) - 1024;
          a[k+6] = 2 * a[k+3] - a[k];
        end
      end
      add_tri(a);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (tri_queue.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    while (normal_queue.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && normal_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
